### rtl/core/dfs_pkg.sv
package dfs_pkg;

    // queue and frame geometry
    localparam int QUEUE_DEPTH = 64;
    localparam int PAUSE_FILL  = 50;
    localparam int FRAME_BITS  = 16;

    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int BIT_IDX_W = $clog2(FRAME_BITS);

    // field widths
    localparam int THR_W   = 11;
    localparam int TICK_W  = 15;
    localparam int LEVEL_W = 3;
    localparam int REG_W   = 15;
    localparam int IDX_W   = 3;

    // throttle handling
    localparam logic [THR_W-1:0] THROTTLE_CAP    = 11'd2000;
    localparam logic [THR_W-1:0] THROTTLE_OFFSET = 11'd47;

    // beacon command range
    localparam logic [LEVEL_W-1:0] BEACON_MIN = 3'd1;
    localparam logic [LEVEL_W-1:0] BEACON_MAX = 3'd5;

    // input item kinds
    typedef enum logic [1:0] {
        MODE_THROTTLE = 2'd0,
        MODE_ARM      = 2'd1,
        MODE_BEACON   = 2'd2,
        MODE_SEND     = 2'd3
    } mode_t;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_MAX_THROTTLE = 3'd0,
        REG_ONE_HIGH     = 3'd1,
        REG_ONE_LOW      = 3'd2,
        REG_ZERO_HIGH    = 3'd3,
        REG_ZERO_LOW     = 3'd4
    } reg_idx_t;

    // bit timing settings seen by the serialiser
    typedef struct packed {
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
    } tick_cfg_t;

    // command ram access from the front end
    typedef struct packed {
        logic              wr_en;
        logic [QPTR_W-1:0] wr_addr;
        logic [THR_W-1:0]  wr_data;
        logic              rd_en;
        logic [QPTR_W-1:0] rd_addr;
    } ram_req_t;

    // value handed to the back end for one frame
    typedef struct packed {
        logic             valid;
        logic [THR_W-1:0] value;
    } frame_push_t;

    // 11-bit value, telemetry bit, nibble xor checksum
    function automatic logic [FRAME_BITS-1:0] frame_of(input logic [THR_W-1:0] value);
        logic [THR_W:0] word;
        logic [3:0]     sum;
        word = {value, 1'b1};
        sum  = word[11:8] ^ word[7:4] ^ word[3:0];
        return {word, sum};
    endfunction

endpackage

### rtl/core/dfs_ram.sv
module dfs_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/dfs_front.sv
module dfs_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  mode,
    input  logic [dfs_pkg::THR_W-1:0]   throttle,
    input  logic                        arm_flag,
    input  logic [dfs_pkg::LEVEL_W-1:0] beep_level,
    input  logic                        pause_before,
    input  logic [dfs_pkg::THR_W-1:0]   max_throttle,
    output dfs_pkg::ram_req_t           ram_req,
    input  logic [dfs_pkg::THR_W-1:0]   ram_rd_data,
    output dfs_pkg::frame_push_t        frame_push,
    input  logic                        frame_full
);

    import dfs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_PAD
    } state_t;

    state_t              state_reg, state_next;
    logic                armed_reg, armed_next;
    logic [THR_W-1:0]    pending_reg, pending_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic [QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    logic                accept;
    logic                do_beacon;
    logic [LEVEL_W-1:0]  beacon_level;

    // circular pointer step for any queue depth
    function automatic logic [QPTR_W-1:0] ptr_step(input logic [QPTR_W-1:0] ptr);
        if (ptr == QPTR_W'(QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return ptr + 1'b1;
    endfunction

    assign full   = (state_reg != S_IDLE) || frame_full;
    assign accept = push && !full;

    // item classification and queue bookkeeping
    always_comb
    begin
        state_next   = state_reg;
        armed_next   = armed_reg;
        pending_next = pending_reg;
        level_next   = level_reg;
        wptr_next    = wptr_reg;
        rptr_next    = rptr_reg;
        count_next   = count_reg;
        ram_req      = '0;
        frame_push   = '0;
        do_beacon    = 1'b0;
        beacon_level = beep_level;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        MODE_THROTTLE:
                        begin
                            pending_next = (throttle > max_throttle) ? max_throttle : throttle;
                        end
                        MODE_ARM:
                        begin
                            armed_next   = arm_flag;
                            pending_next = '0;
                        end
                        MODE_BEACON:
                        begin
                            if (pause_before)
                            begin
                                level_next = beep_level;
                                state_next = S_PAD;
                            end
                            else
                            begin
                                do_beacon = 1'b1;
                            end
                        end
                        MODE_SEND:
                        begin
                            if (count_reg != '0)
                            begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = rptr_reg;
                                rptr_next       = ptr_step(rptr_reg);
                                count_next      = count_reg - 1'b1;
                                state_next      = S_READ;
                            end
                            else
                            begin
                                frame_push.valid = 1'b1;
                                if (armed_reg && (pending_reg != '0))
                                begin
                                    frame_push.value = pending_reg + THROTTLE_OFFSET;
                                end
                                else
                                begin
                                    frame_push.value = '0;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                frame_push.valid = 1'b1;
                frame_push.value = ram_rd_data;
                state_next       = S_IDLE;
            end
            S_PAD:
            begin
                // pause frames one entry a cycle, then the beacon itself
                if (count_reg < QCNT_W'(PAUSE_FILL))
                begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = wptr_reg;
                    ram_req.wr_data = '0;
                    wptr_next       = ptr_step(wptr_reg);
                    count_next      = count_reg + 1'b1;
                end
                else
                begin
                    do_beacon    = 1'b1;
                    beacon_level = level_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // beacon push, dropped when the level is outside the beacon range or the queue is full
        if (do_beacon && (beacon_level >= BEACON_MIN) && (beacon_level <= BEACON_MAX)
            && (count_reg < QCNT_W'(QUEUE_DEPTH)))
        begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = wptr_reg;
            ram_req.wr_data = THR_W'(beacon_level);
            wptr_next       = ptr_step(wptr_reg);
            count_next      = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            armed_reg   <= 1'b0;
            pending_reg <= '0;
            wptr_reg    <= '0;
            rptr_reg    <= '0;
            count_reg   <= '0;
            level_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            armed_reg   <= armed_next;
            pending_reg <= pending_next;
            wptr_reg    <= wptr_next;
            rptr_reg    <= rptr_next;
            count_reg   <= count_next;
            level_reg   <= level_next;
        end
    end

endmodule

### rtl/core/dfs_back.sv
module dfs_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dfs_pkg::frame_push_t           frame_push,
    output logic                           frame_full,
    input  dfs_pkg::tick_cfg_t             ticks,
    output logic                           empty,
    input  logic                           pop,
    output logic                           bit_value,
    output logic [dfs_pkg::TICK_W-1:0]     high_ticks,
    output logic [dfs_pkg::TICK_W-1:0]     low_ticks,
    output logic [dfs_pkg::FRAME_BITS-1:0] frame_word,
    output logic                           last_bit
);

    import dfs_pkg::*;

    localparam int FQ_DEPTH = 2;
    localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
    localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

    logic [THR_W-1:0]      fq_reg [FQ_DEPTH];
    logic [FQ_PTR_W-1:0]   fq_wptr_reg;
    logic [FQ_PTR_W-1:0]   fq_rptr_reg;
    logic [FQ_CNT_W-1:0]   fq_count_reg;

    logic                  active_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [FRAME_BITS-1:0] shift_reg;
    logic [BIT_IDX_W-1:0]  bit_idx_reg;

    logic                  out_take;
    logic                  frame_done;
    logic                  load;
    logic                  fq_pop;

    assign frame_full = (fq_count_reg == FQ_CNT_W'(FQ_DEPTH));
    assign out_take   = pop && active_reg;
    assign frame_done = out_take && (bit_idx_reg == BIT_IDX_W'(FRAME_BITS - 1));
    assign load       = (!active_reg || frame_done) && (fq_count_reg != '0);
    assign fq_pop     = load;

    // frame value queue between front end and serialiser
    always_ff @(posedge clk)
    begin
        if (frame_push.valid)
        begin
            fq_reg[fq_wptr_reg] <= frame_push.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fq_wptr_reg  <= '0;
            fq_rptr_reg  <= '0;
            fq_count_reg <= '0;
        end
        else
        begin
            if (frame_push.valid)
            begin
                fq_wptr_reg <= fq_wptr_reg + 1'b1;
            end
            if (fq_pop)
            begin
                fq_rptr_reg <= fq_rptr_reg + 1'b1;
            end
            fq_count_reg <= fq_count_reg + FQ_CNT_W'(frame_push.valid) - FQ_CNT_W'(fq_pop);
        end
    end

    // serialiser: one bit per result transaction, msb first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            bit_idx_reg <= '0;
        end
        else
        begin
            if (load)
            begin
                active_reg  <= 1'b1;
                bit_idx_reg <= '0;
            end
            else if (frame_done)
            begin
                active_reg <= 1'b0;
            end
            else if (out_take)
            begin
                bit_idx_reg <= bit_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg <= frame_of(fq_reg[fq_rptr_reg]);
            shift_reg <= frame_of(fq_reg[fq_rptr_reg]);
        end
        else if (out_take)
        begin
            shift_reg <= {shift_reg[FRAME_BITS-2:0], 1'b0};
        end
    end

    // result fields
    assign empty      = !active_reg;
    assign bit_value  = shift_reg[FRAME_BITS-1];
    assign high_ticks = bit_value ? ticks.one_high : ticks.zero_high;
    assign low_ticks  = bit_value ? ticks.one_low : ticks.zero_low;
    assign frame_word = frame_reg;
    assign last_bit   = (bit_idx_reg == BIT_IDX_W'(FRAME_BITS - 1));

endmodule

### rtl/core/dshot_frame_sender.sv
// channel   | handshake          | payload
// ----------+--------------------+---------------------------------------------------
// input     | push / full        | mode, throttle, arm_flag, beep_level, pause_before
// result    | pop / empty        | bit_value, high_ticks, low_ticks, frame_word, last_bit
// config    | wr_en              | wr_index, wr_data
//
// throttle, arm and plain beacon items are taken from idle; a padded beacon keeps full high while
// pause entries are written up to PAUSE_FILL, then the beacon, by the single ram write port.
// a send pushes a throttle frame directly, or a queued command read via the registered ram port.
// each frame yields 16 results, one per cycle while pop is held, from the bit serialiser.
// reset is asynchronous active low; the command ram is not cleared, only its count and pointers.
// a stalled result side fills the two-entry frame queue, after which full rises.
module dshot_frame_sender (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     mode,
    input  logic [dfs_pkg::THR_W-1:0]      throttle,
    input  logic                           arm_flag,
    input  logic [dfs_pkg::LEVEL_W-1:0]    beep_level,
    input  logic                           pause_before,
    output logic                           empty,
    input  logic                           pop,
    output logic                           bit_value,
    output logic [dfs_pkg::TICK_W-1:0]     high_ticks,
    output logic [dfs_pkg::TICK_W-1:0]     low_ticks,
    output logic [dfs_pkg::FRAME_BITS-1:0] frame_word,
    output logic                           last_bit,
    input  logic                           wr_en,
    input  logic [dfs_pkg::IDX_W-1:0]      wr_index,
    input  logic [dfs_pkg::REG_W-1:0]      wr_data
);

    import dfs_pkg::*;

    logic [THR_W-1:0] max_throttle_reg;
    tick_cfg_t        ticks_reg;
    logic [THR_W-1:0] wr_thr;

    ram_req_t         ram_req;
    logic [THR_W-1:0] ram_rd_data;
    frame_push_t      frame_push;
    logic             frame_full;

    assign wr_thr = wr_data[THR_W-1:0];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_throttle_reg    <= THROTTLE_CAP;
            ticks_reg.one_high  <= TICK_W'(100);
            ticks_reg.one_low   <= TICK_W'(33);
            ticks_reg.zero_high <= TICK_W'(50);
            ticks_reg.zero_low  <= TICK_W'(83);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_MAX_THROTTLE:
                begin
                    max_throttle_reg <= (wr_thr > THROTTLE_CAP) ? THROTTLE_CAP : wr_thr;
                end
                REG_ONE_HIGH:  ticks_reg.one_high  <= wr_data[TICK_W-1:0];
                REG_ONE_LOW:   ticks_reg.one_low   <= wr_data[TICK_W-1:0];
                REG_ZERO_HIGH: ticks_reg.zero_high <= wr_data[TICK_W-1:0];
                REG_ZERO_LOW:  ticks_reg.zero_low  <= wr_data[TICK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // front end: item handling and command queue control
    dfs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .throttle     (throttle),
        .arm_flag     (arm_flag),
        .beep_level   (beep_level),
        .pause_before (pause_before),
        .max_throttle (max_throttle_reg),
        .ram_req      (ram_req),
        .ram_rd_data  (ram_rd_data),
        .frame_push   (frame_push),
        .frame_full   (frame_full)
    );

    // command queue storage
    dfs_ram #(
        .WIDTH (THR_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data)
    );

    // back end: frame queue and bit serialiser
    dfs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_push (frame_push),
        .frame_full (frame_full),
        .ticks      (ticks_reg),
        .empty      (empty),
        .pop        (pop),
        .bit_value  (bit_value),
        .high_ticks (high_ticks),
        .low_ticks  (low_ticks),
        .frame_word (frame_word),
        .last_bit   (last_bit)
    );

endmodule

### rtl/core/dfs_checker.sv
module dfs_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           empty,
    input logic                           pop,
    input logic                           bit_value,
    input logic [dfs_pkg::FRAME_BITS-1:0] frame_word,
    input logic                           last_bit
);

    import dfs_pkg::*;

    // a waiting result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(frame_word) && $stable(bit_value)
                              && $stable(last_bit)))
        else $error("result changed while stalled");

    // frame carries telemetry bit and a valid checksum
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (frame_word == frame_of(frame_word[FRAME_BITS-1:5])))
        else $error("frame checksum or telemetry bit wrong");

    // bits of one frame follow each other without a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_bit) |=> (!empty && $stable(frame_word)))
        else $error("frame broken before its last bit");

endmodule

bind dshot_frame_sender dfs_checker u_dfs_checker (.*);

### tb/sv/dshot_frame_sender_test.sv
module dshot_frame_sender_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dfs_pkg::*;

    localparam int SETTLE_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 81;
    localparam int PRINT_LIMIT     = 50;

    // one input transaction
    typedef struct packed {
        mode_t              mode;
        logic [THR_W-1:0]   throttle;
        logic               arm;
        logic [LEVEL_W-1:0] level;
        logic               pause;
    } dshot_cmd_t;

    // one bit timing result
    typedef struct packed {
        logic                  bit_value;
        logic [TICK_W-1:0]     high_ticks;
        logic [TICK_W-1:0]     low_ticks;
        logic [FRAME_BITS-1:0] frame_word;
        logic                  last_bit;
    } pulse_t;

    // tracks throttle, arming and the command queue, and holds the pulses still due
    class frame_scoreboard;
        logic [THR_W-1:0]  max_thr;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
        logic              armed;
        logic [THR_W-1:0]  pending_thr;
        logic [THR_W-1:0]  commands[$];
        pulse_t            pulses[$];
        int                errors;
        int                frames;
        int                command_frames;
        int                dropped;
        int                checked;

        function new();
            max_thr        = THROTTLE_CAP;
            one_high       = 15'd100;
            one_low        = 15'd33;
            zero_high      = 15'd50;
            zero_low       = 15'd83;
            armed          = 1'b0;
            pending_thr    = '0;
            errors         = 0;
            frames         = 0;
            command_frames = 0;
            dropped        = 0;
            checked        = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [REG_W-1:0] data);
            case (idx)
                REG_MAX_THROTTLE:
                    max_thr = (data[THR_W-1:0] > THROTTLE_CAP) ? THROTTLE_CAP : data[THR_W-1:0];
                REG_ONE_HIGH:  one_high  = data;
                REG_ONE_LOW:   one_low   = data;
                REG_ZERO_HIGH: zero_high = data;
                REG_ZERO_LOW:  zero_low  = data;
                default: ;
            endcase
        endfunction

        function void note_item(dshot_cmd_t it);
            logic [THR_W-1:0]      value;
            logic [THR_W:0]        word;
            logic [3:0]            csum;
            logic [FRAME_BITS-1:0] frame;
            pulse_t                p;
            case (it.mode)
                MODE_THROTTLE:
                    pending_thr = (it.throttle > max_thr) ? max_thr : it.throttle;
                MODE_ARM:
                begin
                    armed       = it.arm;
                    pending_thr = '0;
                end
                MODE_BEACON:
                begin
                    // pause padding tops the queue up with zero commands
                    if (it.pause)
                        while (commands.size() < PAUSE_FILL)
                            commands.push_back('0);
                    if (it.level >= BEACON_MIN && it.level <= BEACON_MAX)
                    begin
                        if (commands.size() < QUEUE_DEPTH)
                            commands.push_back(THR_W'(it.level));
                        else
                            dropped++;
                    end
                end
                MODE_SEND:
                begin
                    frames++;
                    if (commands.size() != 0)
                    begin
                        value = commands.pop_front();
                        command_frames++;
                    end
                    else if (armed && pending_thr != '0)
                        value = pending_thr + THROTTLE_OFFSET;
                    else
                        value = '0;
                    // telemetry bit then nibble xor checksum
                    word  = {value, 1'b1};
                    csum  = word[3:0] ^ word[7:4] ^ word[11:8];
                    frame = {word, csum};
                    for (int i = FRAME_BITS - 1; i >= 0; i--)
                    begin
                        p.bit_value  = frame[i];
                        p.high_ticks = frame[i] ? one_high : zero_high;
                        p.low_ticks  = frame[i] ? one_low : zero_low;
                        p.frame_word = frame;
                        p.last_bit   = (i == 0);
                        pulses.push_back(p);
                    end
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(pulse_t got);
            pulse_t want;
            if (pulses.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing expected, frame %h", got.frame_word));
                return;
            end
            want = pulses.pop_front();
            checked++;
            if (got.bit_value !== want.bit_value)
                report_mismatch($sformatf("bit_value got %b want %b, frame %h",
                                          got.bit_value, want.bit_value, want.frame_word));
            if (got.high_ticks !== want.high_ticks)
                report_mismatch($sformatf("high_ticks got %0d want %0d, frame %h",
                                          got.high_ticks, want.high_ticks, want.frame_word));
            if (got.low_ticks !== want.low_ticks)
                report_mismatch($sformatf("low_ticks got %0d want %0d, frame %h",
                                          got.low_ticks, want.low_ticks, want.frame_word));
            if (got.frame_word !== want.frame_word)
                report_mismatch($sformatf("frame_word got %h want %h",
                                          got.frame_word, want.frame_word));
            if (got.last_bit !== want.last_bit)
                report_mismatch($sformatf("last_bit got %b want %b, frame %h",
                                          got.last_bit, want.last_bit, want.frame_word));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic [1:0]            mode;
    logic [THR_W-1:0]      throttle;
    logic                  arm_flag;
    logic [LEVEL_W-1:0]    beep_level;
    logic                  pause_before;
    logic                  empty;
    logic                  pop;
    logic                  bit_value;
    logic [TICK_W-1:0]     high_ticks;
    logic [TICK_W-1:0]     low_ticks;
    logic [FRAME_BITS-1:0] frame_word;
    logic                  last_bit;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_index;
    logic [REG_W-1:0]      wr_data;

    frame_scoreboard sb;
    bit              calm;
    int              items_driven;
    int              settings;
    int              idle_cycles;

    dshot_frame_sender dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .throttle     (throttle),
        .arm_flag     (arm_flag),
        .beep_level   (beep_level),
        .pause_before (pause_before),
        .empty        (empty),
        .pop          (pop),
        .bit_value    (bit_value),
        .high_ticks   (high_ticks),
        .low_ticks    (low_ticks),
        .frame_word   (frame_word),
        .last_bit     (last_bit),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // observe both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note_item(dshot_cmd_t'{mode_t'(mode), throttle, arm_flag, beep_level,
                                          pause_before});
            if (pop && !empty)
                sb.check_result(pulse_t'{bit_value, high_ticks, low_ticks, frame_word, last_bit});
        end
    end

    // result side with random stall bursts
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(0, 18)) @(negedge clk);
            end
            else
                pop <= 1'b1;
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic dshot_cmd_t make_item(mode_t m, int thr, bit arm, int lvl, bit pause);
        dshot_cmd_t it;
        it.mode     = m;
        it.throttle = THR_W'(thr);
        it.arm      = arm;
        it.level    = LEVEL_W'(lvl);
        it.pause    = pause;
        return it;
    endfunction

    function automatic dshot_cmd_t any_item(mode_t m);
        return make_item(m, $urandom_range(0, 2047), $urandom_range(0, 1), $urandom_range(0, 7),
                         $urandom_range(0, 1));
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic drive_item(input dshot_cmd_t it);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        push         <= 1'b1;
        mode         <= it.mode;
        throttle     <= it.throttle;
        arm_flag     <= it.arm;
        beep_level   <= it.level;
        pause_before <= it.pause;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
        items_driven++;
    endtask

    // leaves wr_en high, the caller lowers it after the last write
    task automatic write_register(input reg_idx_t idx, input logic [REG_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(negedge clk);
        sb.write_reg(idx, data);
    endtask

    // wait for all pulses, then let any padding finish
    task automatic settle;
        while (sb.pulses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apply_setting(input int phase);
        logic [THR_W-1:0]  thr_cap;
        logic [TICK_W-1:0] ticks[4];
        case (phase)
            1:
            begin
                thr_cap = '0;
                foreach (ticks[i])
                    ticks[i] = 15'd1;
            end
            2:
            begin
                // above the cap, stored as the cap
                thr_cap = '1;
                foreach (ticks[i])
                    ticks[i] = 15'd32767;
            end
            default:
            begin
                thr_cap = (phase == 4) ? THROTTLE_CAP : THR_W'($urandom_range(0, 2000));
                foreach (ticks[i])
                    ticks[i] = TICK_W'($urandom_range(1, 32767));
            end
        endcase
        write_register(REG_MAX_THROTTLE, REG_W'(thr_cap));
        write_register(REG_ONE_HIGH, ticks[0]);
        write_register(REG_ONE_LOW, ticks[1]);
        write_register(REG_ZERO_HIGH, ticks[2]);
        write_register(REG_ZERO_LOW, ticks[3]);
        wr_en <= 1'b0;
        settings++;
    endtask

    task automatic directed_items;
        // reset state: disarmed, nothing queued
        drive_item(make_item(MODE_SEND, 2047, 1, 7, 1));
        drive_item(make_item(MODE_THROTTLE, 500, 1, 7, 1));
        drive_item(make_item(MODE_SEND, 0, 0, 0, 0));
        // armed with zero throttle still sends zero
        drive_item(make_item(MODE_ARM, 2047, 1, 7, 1));
        drive_item(make_item(MODE_SEND, 0, 0, 0, 0));
        drive_item(make_item(MODE_THROTTLE, 1, 0, 0, 0));
        drive_item(make_item(MODE_SEND, 2047, 1, 7, 1));
        // clamped to the cap
        drive_item(make_item(MODE_THROTTLE, 2047, 0, 0, 0));
        drive_item(make_item(MODE_SEND, 0, 0, 0, 0));
        drive_item(make_item(MODE_THROTTLE, 0, 1, 5, 1));
        drive_item(make_item(MODE_SEND, 0, 0, 0, 0));
        // disarm clears the throttle
        drive_item(make_item(MODE_THROTTLE, 1234, 0, 0, 0));
        drive_item(make_item(MODE_ARM, 1234, 0, 3, 1));
        drive_item(make_item(MODE_SEND, 0, 0, 0, 0));
        // levels outside the beacon range queue nothing
        drive_item(make_item(MODE_BEACON, 2047, 1, 0, 0));
        drive_item(make_item(MODE_BEACON, 0, 0, 7, 0));
        for (int lvl = 1; lvl <= 5; lvl++)
            drive_item(make_item(MODE_BEACON, 0, 0, lvl, 0));
        // padding with no command, then padding already reached
        drive_item(make_item(MODE_BEACON, 0, 0, 6, 1));
        drive_item(make_item(MODE_BEACON, 0, 0, 3, 1));
        drive_item(make_item(MODE_SEND, 0, 0, 0, 0));
        drive_item(make_item(MODE_SEND, 0, 0, 0, 0));
    endtask

    task automatic random_traffic(input int count);
        int         stop;
        int         n;
        dshot_cmd_t it;
        stop = items_driven + count;
        while (items_driven < stop)
        begin
            case ($urandom_range(0, 7))
                0, 1:
                begin
                    // optionally arm, set a throttle, send a few frames
                    if ($urandom_range(0, 2) == 0)
                    begin
                        it     = any_item(MODE_ARM);
                        it.arm = ($urandom_range(0, 3) != 0);
                        drive_item(it);
                    end
                    it = any_item(MODE_THROTTLE);
                    if ($urandom_range(0, 3) == 0)
                        it.throttle = $urandom_range(0, 1) ? '1 : sb.max_thr;
                    drive_item(it);
                    repeat ($urandom_range(1, 4)) drive_item(any_item(MODE_SEND));
                end
                2:
                begin
                    // padded beacon burst, can overrun the queue
                    it       = any_item(MODE_BEACON);
                    it.pause = 1'b1;
                    drive_item(it);
                    repeat ($urandom_range(4, 18))
                    begin
                        it       = any_item(MODE_BEACON);
                        it.pause = ($urandom_range(0, 5) == 0);
                        drive_item(it);
                    end
                end
                3, 4:
                begin
                    // drain the command queue and go on to throttle frames
                    n = sb.commands.size() + $urandom_range(1, 3);
                    repeat (n) drive_item(any_item(MODE_SEND));
                end
                5:
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        it       = any_item(MODE_BEACON);
                        it.pause = 1'b0;
                        drive_item(it);
                    end
                    repeat ($urandom_range(1, 3)) drive_item(any_item(MODE_SEND));
                end
                default:
                    repeat ($urandom_range(1, 6)) drive_item(any_item(mode_t'($urandom_range(0, 3))));
            endcase
        end
    endtask

    // main sequence
    initial
    begin
        rst_n        = 1'b0;
        push         = 1'b0;
        mode         = MODE_THROTTLE;
        throttle     = '0;
        arm_flag     = 1'b0;
        beep_level   = '0;
        pause_before = 1'b0;
        wr_en        = 1'b0;
        wr_index     = REG_MAX_THROTTLE;
        wr_data      = '0;
        calm         = 1'b0;
        items_driven = 0;
        settings     = 1;
        sb           = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_items();
        for (int phase = 1; phase <= 5; phase++)
        begin
            push <= 1'b0;
            settle();
            // last phase runs without idling on either side
            if (phase == 5)
                calm = 1'b1;
            apply_setting(phase);
            random_traffic(ITEMS_PER_PHASE);
        end
        push <= 1'b0;

        while (sb.pulses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run: %0d items, %0d frames, %0d taken from the command queue",
                 items_driven, sb.frames, sb.command_frames);
        $display("run: %0d timing settings, %0d bit results checked, %0d beacons dropped",
                 settings, sb.checked, sb.dropped);
        if (sb.errors == 0 && sb.pulses.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
rtl/core/dfs_pkg.sv
rtl/core/dfs_ram.sv
rtl/core/dfs_front.sv
rtl/core/dfs_back.sv
rtl/core/dshot_frame_sender.sv
rtl/core/dfs_checker.sv
tb/sv/dshot_frame_sender_test.sv
